[hw/rtl/u2u_pkg.sv]
`default_nettype none

package u2u_pkg;

  // Replacement unit for malformed input.
  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  // Base values of the two surrogate halves.
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
  // Offset of the high-half index taken off bits 20..10, that is 0x10000 >> 10.
  localparam logic [10:0] SUR_HI_OFFSET = 11'd64;

  // Upper bounds of the byte classes.
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  // Payload masks of the lead bytes and of a continuation byte.
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  // Input command codes.
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  // Class of an incoming byte.
  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_INVALID
  } byte_class_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } out_item_t;

  // Work handed from the front to the back: one or two code units.
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

endpackage

`default_nettype wire

[hw/rtl/u2u_front.sv]
`default_nettype none

module u2u_front
  import u2u_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_item,
  output logic          in_full,
  output logic          q_push,
  input  wire logic     q_full,
  output job_t          q_job
);

  logic [1:0]  pend_r;
  logic [1:0]  pend_nxt;
  logic [20:0] acc_r;
  logic [20:0] acc_nxt;
  logic [20:0] acc_shift;
  logic [10:0] sur_idx;
  logic        accept;
  byte_class_t bclass;
  job_t        job;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Classify the incoming byte by its range.
  always_comb begin
    if (in_item.data_byte <= ASCII_MAX) begin
      bclass = BC_ASCII;
    end else if (in_item.data_byte <= CONT_MAX) begin
      bclass = BC_CONT;
    end else if (in_item.data_byte <= LEAD2_MAX) begin
      bclass = BC_LEAD2;
    end else if (in_item.data_byte <= LEAD3_MAX) begin
      bclass = BC_LEAD3;
    end else if (in_item.data_byte <= LEAD4_MAX) begin
      bclass = BC_LEAD4;
    end else begin
      bclass = BC_INVALID;
    end
  end

  // Accumulator with the continuation payload shifted in, and the high surrogate index.
  assign acc_shift = {acc_r[14:0], in_item.data_byte[5:0] & CONT_MASK[5:0]};
  assign sur_idx   = acc_shift[20:10] - SUR_HI_OFFSET;

  // Decode step: next state and the code units this item produces.
  always_comb begin
    job      = '0;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    if (in_item.command == CMD_END) begin
      if (pend_r != 2'd0) begin
        job.count = 2'd1;
        job.unit0 = REPL_UNIT;
      end
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end else begin
      case (bclass)
        BC_ASCII: begin
          if (pend_r != 2'd0) begin
            job.count = 2'd2;
            job.unit0 = REPL_UNIT;
            job.unit1 = {8'h00, in_item.data_byte};
            pend_nxt  = 2'd0;
          end else begin
            job.count = 2'd1;
            job.unit0 = {8'h00, in_item.data_byte};
          end
        end
        BC_CONT: begin
          if (pend_r != 2'd0) begin
            acc_nxt  = acc_shift;
            pend_nxt = pend_r - 2'd1;
            if (pend_r == 2'd1) begin
              if (acc_shift[20:16] == 5'd0) begin
                job.count = 2'd1;
                job.unit0 = acc_shift[15:0];
              end else begin
                job.count = 2'd2;
                job.unit0 = SUR_HI_BASE + {5'd0, sur_idx};
                job.unit1 = SUR_LO_BASE | {6'd0, acc_shift[9:0]};
              end
            end
          end else begin
            job.count = 2'd1;
            job.unit0 = REPL_UNIT;
          end
        end
        BC_LEAD2: begin
          pend_nxt = 2'd1;
          acc_nxt  = {16'd0, in_item.data_byte[4:0] & LEAD2_MASK[4:0]};
        end
        BC_LEAD3: begin
          pend_nxt = 2'd2;
          acc_nxt  = {17'd0, in_item.data_byte[3:0] & LEAD3_MASK[3:0]};
        end
        BC_LEAD4: begin
          pend_nxt = 2'd3;
          acc_nxt  = {18'd0, in_item.data_byte[2:0] & LEAD4_MASK[2:0]};
        end
        default: begin
          job.count = 2'd1;
          job.unit0 = REPL_UNIT;
          pend_nxt  = 2'd0;
        end
      endcase
    end
  end

  // Decoder state advances only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Items that produce no code unit never enter the queue.
  assign q_push = accept && (job.count != 2'd0);
  assign q_job  = job;

endmodule

`default_nettype wire

[hw/rtl/u2u_queue.sv]
`default_nettype none

module u2u_queue
  import u2u_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  output logic       full,
  input  wire logic  pop,
  output job_t       pop_job,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots_r[rd_ptr_r];

  // Pointer and occupancy update with wrap at the last slot.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/u2u_back.sv]
`default_nettype none

module u2u_back
  import u2u_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire job_t  q_job,
  output logic       q_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output out_item_t  out_item
);

  logic      hold_vld_r;
  logic      hold_vld_nxt;
  logic      second_r;
  logic      second_nxt;
  job_t      hold_r;
  job_t      hold_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t out_r;
  out_item_t out_nxt;
  logic      load_out;
  logic      cur_last;
  logic      hold_free;

  // The output register takes a new unit whenever a job is held and it is empty or being drained.
  assign load_out  = hold_vld_r && (!out_vld_r || (out_pop && out_vld_r));
  assign cur_last  = second_r || (hold_r.count == 2'd1);
  assign hold_free = !hold_vld_r || (load_out && cur_last);
  assign q_pop     = hold_free && q_valid;

  // Sequence the units of the held job into the output register.
  always_comb begin
    hold_vld_nxt = hold_vld_r;
    second_nxt   = second_r;
    hold_nxt     = hold_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    if (q_pop) begin
      hold_vld_nxt = 1'b1;
      second_nxt   = 1'b0;
      hold_nxt     = q_job;
    end else if (load_out && cur_last) begin
      hold_vld_nxt = 1'b0;
      second_nxt   = 1'b0;
    end else if (load_out) begin
      second_nxt = 1'b1;
    end
    if (load_out) begin
      out_vld_nxt       = 1'b1;
      out_nxt.code_unit = second_r ? hold_r.unit1 : hold_r.unit0;
      out_nxt.last      = cur_last;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      second_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      second_r   <= second_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

[hw/rtl/utf8_to_utf16_decoder_core.sv]
`default_nettype none

// UTF-8 to UTF-16 stream decoder. One UTF-8 byte (or an end-of-string command) is
// taken per item and the block may accept one item every clock cycle while in_full
// is low; the decode itself completes in the cycle of acceptance. Each item yields
// zero, one or two UTF-16 code units, and the result side delivers one unit per
// cycle while results are popped. A job queue of QUEUE_DEPTH entries sits between
// the decoder and the result sequencer; full rises only when that queue is full,
// which happens when items yield units faster than the result side emits them or
// when results are not popped. The first result of an item passes through the job
// queue, the sequencer's hold register and its output register. Malformed bytes
// produce 0xFFFD; no overlong or range checks are made.
module utf8_to_utf16_decoder_core
  import u2u_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_item,
  output logic          in_full,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_item
);

  job_t  push_job;
  job_t  pop_job;
  logic  q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_valid;
  logic  q_pop;

  // Decoder: classifies bytes and keeps the sequence state.
  u2u_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_job   (push_job)
  );

  // Job queue between the decoder and the result sequencer.
  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  assign q_valid = !q_empty;

  // Result sequencer: emits the units of each job, one per cycle while results are popped.
  u2u_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[hw/rtl/u2u_checker.sv]
`default_nettype none

module u2u_checker
  import u2u_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_push,
  input wire in_item_t  in_item,
  input wire logic      in_full,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_item
);

  // Nothing is waiting on the result side straight after reset.
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // The decoder is ready to take an item straight after reset.
  assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed");

  // The second unit of an item follows its first without a gap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_item.last) |=> !out_empty)
    else $error("second unit of an item not ready");

  // Only a surrogate half or a replacement can be followed by more units of its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.last) |->
      ((out_item.code_unit[15:11] == 5'b11011) || (out_item.code_unit == REPL_UNIT)))
    else $error("unexpected first unit of a two-unit item");

endmodule

bind utf8_to_utf16_decoder_core u2u_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_item   (in_item),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

`default_nettype wire

[tb/testbench.sv]
module testbench
  import u2u_pkg::*;
();

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BYTES = 1810;
  localparam logic [20:0] PLANE1_BASE  = 21'h10000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_item;
  logic      in_full;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_item;

  // Decoder state as the testbench sees it.
  logic [1:0]  want_count = '0;
  logic [20:0] code_acc = '0;

  out_item_t   expected_units[$];
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  // When set, neither side idles.
  bit          quiet = 1'b0;
  // Asks the receiver for one long hold-off.
  bit          hold_req = 1'b0;

  utf8_to_utf16_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Work out the code units that one accepted item produces and queue them.
  task automatic decode_byte(input in_item_t it);
    logic [15:0] units [2];
    int          n;
    logic [20:0] v;
    out_item_t   r;
    n = 0;
    if (it.command == CMD_END) begin
      if (want_count != 0) begin
        units[n] = REPL_UNIT;
        n++;
      end
      want_count = '0;
      code_acc = '0;
    end else if (it.data_byte <= ASCII_MAX) begin
      // ASCII cuts short any pending sequence with a replacement first.
      if (want_count != 0) begin
        units[n] = REPL_UNIT;
        n++;
        want_count = '0;
      end
      units[n] = {8'h00, it.data_byte};
      n++;
    end else if (it.data_byte <= CONT_MAX) begin
      if (want_count != 0) begin
        code_acc = {code_acc[14:0], it.data_byte[5:0]};
        want_count = want_count - 2'd1;
        if (want_count == 0) begin
          if (code_acc < PLANE1_BASE) begin
            units[n] = code_acc[15:0];
            n++;
          end else begin
            v = code_acc - PLANE1_BASE;
            units[n] = SUR_HI_BASE + 16'(v[20:10]);
            n++;
            units[n] = SUR_LO_BASE + 16'(v[9:0]);
            n++;
          end
        end
      end else begin
        // A continuation with nothing pending is replaced.
        units[n] = REPL_UNIT;
        n++;
      end
    end else if (it.data_byte <= LEAD2_MAX) begin
      want_count = 2'd1;
      code_acc = 21'(it.data_byte & LEAD2_MASK);
    end else if (it.data_byte <= LEAD3_MAX) begin
      want_count = 2'd2;
      code_acc = 21'(it.data_byte & LEAD3_MASK);
    end else if (it.data_byte <= LEAD4_MAX) begin
      want_count = 2'd3;
      code_acc = 21'(it.data_byte & LEAD4_MASK);
    end else begin
      units[n] = REPL_UNIT;
      n++;
      want_count = '0;
    end
    for (int i = 0; i < n; i++) begin
      r.code_unit = units[i];
      r.last = (i == n - 1);
      expected_units = {expected_units, r};
    end
  endtask

  // Offer one item until it is accepted, then idle for a random gap.
  task automatic push_item(input cmd_t cmd, input logic [7:0] b);
    in_item_t    it;
    int unsigned gap;
    it.command = cmd;
    it.data_byte = b;
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    decode_byte(it);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(CMD_DATA, b);
  endtask

  // One character of the given length and random content; conts below the needed
  // number leave the sequence unfinished.
  task automatic push_char(input int unsigned len, input int unsigned conts);
    case (len)
      1: begin
        push_byte(8'($urandom_range(0, 127)));
      end
      2: begin
        push_byte(8'hC0 | 8'($urandom_range(0, 31)));
      end
      3: begin
        push_byte(8'hE0 | 8'($urandom_range(0, 15)));
      end
      default: begin
        push_byte(8'hF0 | 8'($urandom_range(0, 7)));
      end
    endcase
    for (int i = 0; i < conts; i++) begin
      push_byte(8'h80 | 8'($urandom_range(0, 63)));
    end
  endtask

  // Lowest and highest ASCII bytes.
  task automatic test_ascii();
    push_byte(8'h00);
    push_byte(8'h7F);
  endtask

  // Largest values of two, three and four byte sequences, the last one
  // well beyond the Unicode range.
  task automatic test_sequences();
    push_byte(8'hDF);
    push_byte(8'hBF);
    push_byte(8'hEF);
    push_byte(8'hBF);
    push_byte(8'hBF);
    push_byte(8'hF7);
    push_byte(8'hBF);
    push_byte(8'hBF);
    push_byte(8'hBF);
  endtask

  // Malformed input of every kind the decoder recognises.
  task automatic test_malformed();
    // ASCII in the middle of a sequence.
    push_byte(8'hC3);
    push_byte(8'h41);
    // Continuation with nothing pending.
    push_byte(8'h80);
    // A new lead byte drops the sequence before it.
    push_byte(8'hE2);
    push_byte(8'hC3);
    push_byte(8'hA9);
    // Invalid bytes, alone and mid-sequence.
    push_byte(8'hFF);
    push_byte(8'hF0);
    push_byte(8'hF8);
    // End of string with and without a pending sequence.
    push_byte(8'hF0);
    push_item(CMD_END, 8'hFF);
    push_item(CMD_END, 8'h00);
  endtask

  // The receiver holds off while surrogate pairs keep arriving, so the
  // job queue fills and the input stalls.
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      push_char(4, 3);
    end
    quiet = 1'b0;
  endtask

  // Mostly well-formed text with random content, mixed with broken
  // sequences, stray bytes and end commands.
  task automatic test_random();
    int unsigned r;
    int unsigned len;
    int unsigned target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 39) == 0) begin
        quiet = ~quiet;
      end
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (r < 75) begin
        push_char(len, len - 1);
      end else if (r < 85) begin
        push_char($urandom_range(2, 4), $urandom_range(0, len - 1));
      end else if (r < 90) begin
        push_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (r < 94) begin
        push_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (r < 97) begin
        push_item(CMD_END, 8'($urandom_range(0, 255)));
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    int unsigned gap;
    out_pop <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_pop <= 1'b1;
        end else begin
          stall = gap - 1;
          out_pop <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted code unit with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("unexpected unit %h last %b",
                                  out_item.code_unit, out_item.last));
      end else begin
        want = expected_units.pop_front();
        if (out_item.code_unit !== want.code_unit) begin
          report_mismatch($sformatf("code_unit %h, expected %h",
                                    out_item.code_unit, want.code_unit));
        end
        if (out_item.last !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b on unit %h",
                                    out_item.last, want.last, want.code_unit));
        end
      end
    end
  end

  // Guard against a hang.
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // Reset, run every test in turn, drain and report.
  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_ascii();
    test_sequences();
    test_malformed();
    test_backpressure();
    test_random();
    in_push <= 1'b0;
    while (expected_units.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
